[rtl/btlv_pkg.sv]
// btlv_pkg: shared types and constants for the ber tlv header tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package btlv_pkg;

  // longest long-form length field that is accepted, in bytes
  localparam int unsigned MaxLengthBytes = 8;

  localparam logic [7:0] ClassMask       = 8'b1100_0000;
  localparam logic [7:0] ConstructedMask = 8'b0010_0000;
  localparam logic [7:0] TagMask         = 8'b0001_1111;
  localparam logic [7:0] LongFlag        = 8'h80;
  localparam logic [7:0] LowSevenMask    = 8'h7F;
  localparam logic [7:0] ZeroByte        = 8'h00;

  typedef enum logic [2:0] {
    PhIdent   = 3'd0,
    PhTagLong = 3'd1,
    PhLen     = 3'd2,
    PhLenLong = 3'd3,
    PhContent = 3'd4,
    PhError   = 3'd5
  } btlv_phase_e;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindContent = 2'd1,
    KindError   = 2'd2
  } btlv_kind_e;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrLenLong   = 2'd1,
    ErrIndefPrim = 2'd2
  } btlv_err_e;

  // one raw request from the byte stream
  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_message;
  } btlv_byte_t;

  // one result token
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tag_class;
    logic        is_constructed;
    logic [31:0] tag_number;
    logic [63:0] length_value;
    logic        is_indefinite;
    logic        is_end_of_contents;
    logic [7:0]  content_byte;
    logic        is_last_content;
    logic [1:0]  error_code;
  } btlv_token_t;

endpackage

`default_nettype wire

[rtl/btlv_if.sv]
// btlv_in_if and btlv_out_if: valid/ready channels of the tokenizer
// no dependencies
`default_nettype none

interface btlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_of_message;

  modport source (output valid, output byte_value, output start_of_message, input ready);
  modport sink   (input valid, input byte_value, input start_of_message, output ready);
endinterface

interface btlv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  tag_class;
  logic        is_constructed;
  logic [31:0] tag_number;
  logic [63:0] length_value;
  logic        is_indefinite;
  logic        is_end_of_contents;
  logic [7:0]  content_byte;
  logic        is_last_content;
  logic [1:0]  error_code;

  modport source (
    output valid, output kind, output tag_class, output is_constructed,
    output tag_number, output length_value, output is_indefinite,
    output is_end_of_contents, output content_byte, output is_last_content,
    output error_code, input ready
  );
  modport sink (
    input valid, input kind, input tag_class, input is_constructed,
    input tag_number, input length_value, input is_indefinite,
    input is_end_of_contents, input content_byte, input is_last_content,
    input error_code, output ready
  );
endinterface

`default_nettype wire

[rtl/ber_tlv_header_tokenizer.sv]
// ber_tlv_header_tokenizer: one stream byte per cycle while the result register is not held
// path: input register, then decode, then any token of the byte into the result register
// throughput: one byte every cycle unless the output stalls; set by the single decode
// step between the input register and the result register
// reset: async active low, parser returns to expecting an identifier, both
// registers empty; depends on btlv_pkg, btlv_if, btlv_in_stage, btlv_decoder, btlv_out_stage
`default_nettype none

module ber_tlv_header_tokenizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  btlv_in_if.sink   in_i,
  btlv_out_if.source out_o
);
  import btlv_pkg::*;

  logic        s1_valid;
  btlv_byte_t  s1_data;
  logic        out_free;
  logic        fire;
  logic        emit;
  btlv_token_t token;

  // a buffered request is decoded once the result register can take its token
  assign fire = s1_valid && out_free;

  // input register; ready is high when it is empty or its request moves on this cycle
  btlv_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (fire),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  // parse state: identifier, tag, length, content pass-through, error latch
  btlv_decoder u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .data_i  (s1_data),
    .emit_o  (emit),
    .token_o (token)
  );

  // result register; bytes inside a header produce no token and load nothing
  btlv_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .token_i (token),
    .free_o  (out_free),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

[rtl/btlv_in_stage.sv]
// btlv_in_stage: input register in front of the decoder
// depends on btlv_pkg and btlv_in_if
`default_nettype none

module btlv_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  btlv_in_if.sink                  in_i,
  input  wire logic                take_i,
  output      logic                valid_o,
  output      btlv_pkg::btlv_byte_t data_o
);
  import btlv_pkg::*;

  logic       valid_q, valid_d;
  btlv_byte_t data_q;
  logic       load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q.byte_value       <= in_i.byte_value;
      data_q.start_of_message <= in_i.start_of_message;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/btlv_decoder.sv]
// btlv_decoder: parse state and one-byte decode step of the tokenizer
// depends on btlv_pkg
`default_nettype none

module btlv_decoder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire btlv_pkg::btlv_byte_t data_i,
  output      logic                 emit_o,
  output      btlv_pkg::btlv_token_t token_o
);
  import btlv_pkg::*;

  btlv_phase_e phase_q, phase_d;
  logic [1:0]  class_q, class_d;
  logic        cons_q, cons_d;
  logic        eoc_ident_q, eoc_ident_d;
  logic [31:0] tag_q, tag_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [63:0] content_left_q, content_left_d;

  always_comb begin
    btlv_phase_e ph;
    logic [7:0]  b;
    logic [6:0]  n;
    logic [3:0]  left_dec;
    logic [63:0] cl_dec;
    logic [63:0] acc_new;
    logic        hdr_go;
    logic [63:0] hdr_len;
    logic        hdr_indef;
    logic        hdr_eoc;

    phase_d        = phase_q;
    class_d        = class_q;
    cons_d         = cons_q;
    eoc_ident_d    = eoc_ident_q;
    tag_d          = tag_q;
    len_acc_d      = len_acc_q;
    len_left_d     = len_left_q;
    content_left_d = content_left_q;
    token_o        = '0;
    emit_o         = 1'b0;
    hdr_go         = 1'b0;
    hdr_len        = '0;
    hdr_indef      = 1'b0;
    hdr_eoc        = 1'b0;

    b        = data_i.byte_value;
    n        = b[6:0];
    ph       = data_i.start_of_message ? PhIdent : phase_q;
    left_dec = (len_left_q != 4'd0) ? len_left_q - 4'd1 : 4'd0;
    cl_dec   = (content_left_q != 64'd0) ? content_left_q - 64'd1 : 64'd0;
    acc_new  = {len_acc_q[55:0], b};

    if (fire_i) begin
      case (ph)
        PhIdent: begin
          class_d     = b[7:6];
          cons_d      = |(b & ConstructedMask);
          eoc_ident_d = (b == ZeroByte);
          len_acc_d   = '0;
          len_left_d  = '0;
          if ((b & TagMask) == TagMask) begin
            tag_d   = '0;
            phase_d = PhTagLong;
          end else begin
            tag_d   = {27'd0, b[4:0]};
            phase_d = PhLen;
          end
        end
        PhTagLong: begin
          // 7 bits per byte, high bits fall off the top
          tag_d = {tag_q[24:0], b[6:0]};
          if (!b[7]) begin
            phase_d = PhLen;
          end
        end
        PhLen: begin
          if (b == LongFlag) begin
            if (!cons_q) begin
              emit_o             = 1'b1;
              token_o.kind       = KindError;
              token_o.error_code = ErrIndefPrim;
              phase_d            = PhError;
            end else begin
              hdr_go    = 1'b1;
              hdr_indef = 1'b1;
            end
          end else if (!b[7]) begin
            hdr_go  = 1'b1;
            hdr_len = {56'd0, b};
            hdr_eoc = eoc_ident_q && (b == ZeroByte);
          end else if (n > 7'(MaxLengthBytes)) begin
            emit_o             = 1'b1;
            token_o.kind       = KindError;
            token_o.error_code = ErrLenLong;
            phase_d            = PhError;
          end else begin
            len_acc_d  = '0;
            len_left_d = n[3:0];
            phase_d    = PhLenLong;
          end
        end
        PhLenLong: begin
          len_acc_d  = acc_new;
          len_left_d = left_dec;
          if (left_dec == 4'd0) begin
            hdr_go  = 1'b1;
            hdr_len = acc_new;
          end
        end
        PhContent: begin
          emit_o               = 1'b1;
          token_o.kind         = KindContent;
          token_o.content_byte = b;
          content_left_d       = cl_dec;
          if (cl_dec == 64'd0) begin
            token_o.is_last_content = 1'b1;
            phase_d                 = PhIdent;
          end
        end
        default: begin
          // latched error: drop bytes until restart
        end
      endcase

      if (hdr_go) begin
        emit_o                     = 1'b1;
        token_o.kind               = KindHeader;
        token_o.tag_class          = class_q;
        token_o.is_constructed     = cons_q;
        token_o.tag_number         = tag_q;
        token_o.length_value       = hdr_indef ? 64'd0 : hdr_len;
        token_o.is_indefinite      = hdr_indef;
        token_o.is_end_of_contents = hdr_eoc;
        if (!hdr_indef && !cons_q && (hdr_len != 64'd0)) begin
          content_left_d = hdr_len;
          phase_d        = PhContent;
        end else begin
          content_left_d = '0;
          phase_d        = PhIdent;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdent;
      class_q        <= '0;
      cons_q         <= 1'b0;
      eoc_ident_q    <= 1'b0;
      tag_q          <= '0;
      len_acc_q      <= '0;
      len_left_q     <= '0;
      content_left_q <= '0;
    end else begin
      phase_q        <= phase_d;
      class_q        <= class_d;
      cons_q         <= cons_d;
      eoc_ident_q    <= eoc_ident_d;
      tag_q          <= tag_d;
      len_acc_q      <= len_acc_d;
      len_left_q     <= len_left_d;
      content_left_q <= content_left_d;
    end
  end

endmodule

`default_nettype wire

[rtl/btlv_out_stage.sv]
// btlv_out_stage: result register driving the output channel
// depends on btlv_pkg and btlv_out_if
`default_nettype none

module btlv_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire btlv_pkg::btlv_token_t token_i,
  output      logic                  free_o,
  btlv_out_if.source                 out_o
);
  import btlv_pkg::*;

  logic        valid_q, valid_d;
  btlv_token_t token_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      token_q <= token_i;
    end
  end

  assign out_o.valid              = valid_q;
  assign out_o.kind               = token_q.kind;
  assign out_o.tag_class          = token_q.tag_class;
  assign out_o.is_constructed     = token_q.is_constructed;
  assign out_o.tag_number         = token_q.tag_number;
  assign out_o.length_value       = token_q.length_value;
  assign out_o.is_indefinite      = token_q.is_indefinite;
  assign out_o.is_end_of_contents = token_q.is_end_of_contents;
  assign out_o.content_byte       = token_q.content_byte;
  assign out_o.is_last_content    = token_q.is_last_content;
  assign out_o.error_code         = token_q.error_code;

endmodule

`default_nettype wire
